FILE: design/otrq_pkg.sv
// ----------------------------------------------------------------------------
// otrq_pkg
// Shared types and constants for the ordered timer request queue.
// ----------------------------------------------------------------------------
package otrq_pkg;

  localparam int unsigned PoolSize = 16;
  localparam int unsigned IdxW     = $clog2(PoolSize);
  localparam int unsigned LinkW    = $clog2(PoolSize + 1);
  localparam int unsigned SemW     = 8;
  localparam int unsigned MsgW     = 16;
  localparam int unsigned TickW    = 16;
  localparam int unsigned CountW   = 5;

  typedef logic [LinkW-1:0] link_t;
  typedef logic [IdxW-1:0]  idx_t;

  // null link, one past the last slot
  localparam link_t NilLink = link_t'(PoolSize);

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpCancel = 2'd1;
  localparam logic [1:0] OpTick   = 2'd2;

  localparam logic [1:0] KindInsert  = 2'd0;
  localparam logic [1:0] KindCancel  = 2'd1;
  localparam logic [1:0] KindExpiry  = 2'd2;
  localparam logic [1:0] KindTickEnd = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic       load_in;    // latch input word, start walk at head
    logic       rd_en;      // read slot memories
    logic       rd_free;    // read at free head rather than cursor
    logic       alloc;      // pop free head, store new request
    logic       advance;    // prev <= cur, cur <= next
    logic       link_new;   // next[new] <= cur
    logic       link_prev;  // next[prev] (or head) <= new
    logic       unlink;     // next[prev] (or head) <= next[cur]
    logic       take_left;  // capture ticks of the removed entry
    logic       tick_wr;    // write back decremented count
    logic       free_cur;   // push cur on free chain, cur <= saved next
    logic       emit;       // load output register
    logic [1:0] emit_kind;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cur_nil;
    logic free_empty;
    logic later;    // new count above the visited entry's count
    logic match;    // visited entry matches semaphore and message
    logic expire;   // visited entry reaches zero on this tick
    logic out_free;
  } stat_t;

endpackage

FILE: design/ordered_timer_request_queue_top.sv
// ----------------------------------------------------------------------------
// ordered_timer_request_queue_top
// Pool of sixteen timer requests kept as a list sorted by tick count.
// ----------------------------------------------------------------------------
// One word is taken at a time, in the idle cycle, and each list entry is
// visited through the single read port of the slot memories. An insert
// allocates a slot from the free chain, walks past the entries with smaller
// counts and links the new entry in; an insert into a full pool skips the
// walk. A cancel walks the whole list and removes every match; a tick walks
// the whole list, decrements each count and presents one result word per
// expiry. Each result word waits while the output is stalled, and the next
// word is taken only once the controller is idle again. The result register
// lets the next word in while the last result of the previous one still
// waits. No clearing pass is needed after reset.
module ordered_timer_request_queue_top
  import otrq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        opcode_i,
  input  logic [SemW-1:0]   sem_number_i,
  input  logic [MsgW-1:0]   message_i,
  input  logic [TickW-1:0]  tick_count_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        kind_o,
  output logic [SemW-1:0]   out_sem_o,
  output logic [MsgW-1:0]   out_message_o,
  output logic [TickW-1:0]  ticks_left_o,
  output logic [CountW-1:0] free_entries_o,
  output logic [CountW-1:0] free_low_mark_o,
  output logic              pool_error_o,
  output logic              last_o
);

  cmd_t  cmd;
  stat_t stat;

  otrq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  otrq_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .sem_number_i    (sem_number_i),
    .message_i       (message_i),
    .tick_count_i    (tick_count_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .out_sem_o       (out_sem_o),
    .out_message_o   (out_message_o),
    .ticks_left_o    (ticks_left_o),
    .free_entries_o  (free_entries_o),
    .free_low_mark_o (free_low_mark_o),
    .pool_error_o    (pool_error_o),
    .last_o          (last_o)
  );

endmodule

FILE: design/otrq_dp.sv
// ----------------------------------------------------------------------------
// otrq_dp
// Slot memories, list pointers, counters and the result register.
// ----------------------------------------------------------------------------
module otrq_dp
  import otrq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  input  logic [SemW-1:0]   sem_number_i,
  input  logic [MsgW-1:0]   message_i,
  input  logic [TickW-1:0]  tick_count_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        kind_o,
  output logic [SemW-1:0]   out_sem_o,
  output logic [MsgW-1:0]   out_message_o,
  output logic [TickW-1:0]  ticks_left_o,
  output logic [CountW-1:0] free_entries_o,
  output logic [CountW-1:0] free_low_mark_o,
  output logic              pool_error_o,
  output logic              last_o
);

  logic [SemW-1:0]  sem_mem  [PoolSize];
  logic [MsgW-1:0]  msg_mem  [PoolSize];
  logic [TickW-1:0] tick_mem [PoolSize];
  link_t            next_mem [PoolSize];
  logic [PoolSize-1:0] next_vld_q;

  link_t active_head_q, free_head_q, cur_q, prev_q, nxt_q;
  idx_t  new_slot_q;
  logic [SemW-1:0]   sem_q, rd_sem_q;
  logic [MsgW-1:0]   msg_q, rd_msg_q;
  logic [TickW-1:0]  tval_q, left_q, rd_tick_q;
  link_t             rd_next_q;
  logic [CountW-1:0] count_q, min_q, count_dec;

  logic [TickW-1:0] tick_dec;
  idx_t             rd_idx, cur_idx, prev_idx;
  logic             prev_nil;
  logic             nx_we;
  idx_t             nx_addr;
  link_t            nx_data;
  logic             tk_we;
  idx_t             tk_addr;
  logic [TickW-1:0] tk_data;

  logic              out_valid_q;
  logic [1:0]        kind_q;
  logic [SemW-1:0]   osem_q;
  logic [MsgW-1:0]   omsg_q;
  logic [TickW-1:0]  oleft_q;
  logic [CountW-1:0] ofree_q, omin_q;
  logic              oerr_q, olast_q;

  assign cur_idx   = cur_q[IdxW-1:0];
  assign prev_idx  = prev_q[IdxW-1:0];
  assign prev_nil  = (prev_q == NilLink);
  assign rd_idx    = cmd_i.rd_free ? free_head_q[IdxW-1:0] : cur_idx;
  assign tick_dec  = (rd_tick_q != '0) ? rd_tick_q - 1'b1 : '0;
  assign count_dec = count_q - 1'b1;

  // single write port on the link memory
  always_comb begin
    nx_we   = 1'b0;
    nx_addr = cur_idx;
    nx_data = free_head_q;
    if (cmd_i.link_new) begin
      nx_we   = 1'b1;
      nx_addr = new_slot_q;
      nx_data = cur_q;
    end else if (cmd_i.link_prev) begin
      nx_we   = !prev_nil;
      nx_addr = prev_idx;
      nx_data = link_t'(new_slot_q);
    end else if (cmd_i.unlink) begin
      nx_we   = !prev_nil;
      nx_addr = prev_idx;
      nx_data = rd_next_q;
    end else if (cmd_i.free_cur) begin
      nx_we   = 1'b1;
    end
  end

  always_comb begin
    tk_we   = cmd_i.alloc | cmd_i.tick_wr;
    tk_addr = cmd_i.alloc ? free_head_q[IdxW-1:0] : cur_idx;
    tk_data = cmd_i.alloc ? tval_q : tick_dec;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) begin
      sem_mem[free_head_q[IdxW-1:0]] <= sem_q;
      msg_mem[free_head_q[IdxW-1:0]] <= msg_q;
    end
    if (tk_we) begin
      tick_mem[tk_addr] <= tk_data;
    end
    if (nx_we) begin
      next_mem[nx_addr] <= nx_data;
    end
  end

  // registered read; a link never written reads as its initial value i+1
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_sem_q  <= sem_mem[rd_idx];
      rd_msg_q  <= msg_mem[rd_idx];
      rd_tick_q <= tick_mem[rd_idx];
      rd_next_q <= next_vld_q[rd_idx] ? next_mem[rd_idx] : link_t'(rd_idx) + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_vld_q    <= '0;
      active_head_q <= NilLink;
      free_head_q   <= '0;
      count_q       <= CountW'(PoolSize);
      min_q         <= CountW'(PoolSize);
    end else begin
      if (nx_we) begin
        next_vld_q[nx_addr] <= 1'b1;
      end
      if (cmd_i.link_prev && prev_nil) begin
        active_head_q <= link_t'(new_slot_q);
      end else if (cmd_i.unlink && prev_nil) begin
        active_head_q <= rd_next_q;
      end
      if (cmd_i.alloc) begin
        free_head_q <= rd_next_q;
        count_q     <= count_dec;
        if (count_dec < min_q) begin
          min_q <= count_dec;
        end
      end else if (cmd_i.free_cur) begin
        free_head_q <= cur_q;
        count_q     <= count_q + 1'b1;
      end
    end
  end

  // walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      sem_q  <= sem_number_i;
      msg_q  <= message_i;
      tval_q <= tick_count_i;
      left_q <= '0;
      cur_q  <= active_head_q;
      prev_q <= NilLink;
    end
    if (cmd_i.alloc) begin
      new_slot_q <= free_head_q[IdxW-1:0];
    end
    if (cmd_i.advance) begin
      prev_q <= cur_q;
      cur_q  <= rd_next_q;
    end
    if (cmd_i.unlink) begin
      nxt_q <= rd_next_q;
    end
    if (cmd_i.take_left) begin
      left_q <= rd_tick_q;
    end
    if (cmd_i.free_cur) begin
      cur_q <= nxt_q;
    end
  end

  assign stat_o.cur_nil    = (cur_q == NilLink);
  assign stat_o.free_empty = (count_q == '0);
  assign stat_o.later      = (tval_q > rd_tick_q);
  assign stat_o.match      = (rd_sem_q == sem_q) && (rd_msg_q == msg_q);
  assign stat_o.expire     = (tick_dec == '0);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q  <= cmd_i.emit_kind;
      osem_q  <= (cmd_i.emit_kind == KindExpiry) ? rd_sem_q : '0;
      omsg_q  <= (cmd_i.emit_kind == KindExpiry) ? rd_msg_q : '0;
      oleft_q <= (cmd_i.emit_kind == KindCancel) ? left_q : '0;
      ofree_q <= count_q;
      omin_q  <= min_q;
      // insert flags an empty pool, whether it took the last slot or bounced
      oerr_q  <= (cmd_i.emit_kind == KindInsert) && (count_q == '0);
      olast_q <= (cmd_i.emit_kind != KindExpiry);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign out_sem_o       = osem_q;
  assign out_message_o   = omsg_q;
  assign ticks_left_o    = oleft_q;
  assign free_entries_o  = ofree_q;
  assign free_low_mark_o = omin_q;
  assign pool_error_o    = oerr_q;
  assign last_o          = olast_q;

endmodule

FILE: design/otrq_ctrl.sv
// ----------------------------------------------------------------------------
// otrq_ctrl
// Sequencer for insert, cancel and tick list walks.
// ----------------------------------------------------------------------------
module otrq_ctrl
  import otrq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  stat_t      stat_i,
  output cmd_t       cmd_o
);

  localparam logic [3:0] SIdle     = 4'd0;
  localparam logic [3:0] SInsChk   = 4'd1;
  localparam logic [3:0] SInsAlloc = 4'd2;
  localparam logic [3:0] SWalkRd   = 4'd3;
  localparam logic [3:0] SWalkCmp  = 4'd4;
  localparam logic [3:0] SLinkA    = 4'd5;
  localparam logic [3:0] SLinkB    = 4'd6;
  localparam logic [3:0] SCanRd    = 4'd7;
  localparam logic [3:0] SCanCmp   = 4'd8;
  localparam logic [3:0] SCanRel   = 4'd9;
  localparam logic [3:0] STickRd   = 4'd10;
  localparam logic [3:0] STickCmp  = 4'd11;
  localparam logic [3:0] STickRel  = 4'd12;
  localparam logic [3:0] STickEmit = 4'd13;
  localparam logic [3:0] SEmit     = 4'd14;

  logic [3:0] state_q, state_d;
  logic [1:0] op_q, op_d;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d          = opcode_i;
          cmd_o.load_in = 1'b1;
          case (opcode_i)
            OpInsert: state_d = SInsChk;
            OpCancel: state_d = SCanRd;
            OpTick:   state_d = STickRd;
            default:  state_d = SIdle;
          endcase
        end
      end
      SInsChk: begin
        if (stat_i.free_empty) begin
          state_d = SEmit;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_free = 1'b1;
          state_d       = SInsAlloc;
        end
      end
      SInsAlloc: begin
        cmd_o.alloc = 1'b1;
        state_d     = SWalkRd;
      end
      SWalkRd: begin
        if (stat_i.cur_nil) begin
          state_d = SLinkA;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = SWalkCmp;
        end
      end
      SWalkCmp: begin
        if (stat_i.later) begin
          cmd_o.advance = 1'b1;
          state_d       = SWalkRd;
        end else begin
          state_d = SLinkA;
        end
      end
      SLinkA: begin
        cmd_o.link_new = 1'b1;
        state_d        = SLinkB;
      end
      SLinkB: begin
        cmd_o.link_prev = 1'b1;
        state_d         = SEmit;
      end
      SCanRd: begin
        if (stat_i.cur_nil) begin
          state_d = SEmit;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = SCanCmp;
        end
      end
      SCanCmp: begin
        if (stat_i.match) begin
          cmd_o.unlink    = 1'b1;
          cmd_o.take_left = 1'b1;
          state_d         = SCanRel;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = SCanRd;
        end
      end
      SCanRel: begin
        cmd_o.free_cur = 1'b1;
        state_d        = SCanRd;
      end
      STickRd: begin
        if (stat_i.cur_nil) begin
          state_d = SEmit;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = STickCmp;
        end
      end
      STickCmp: begin
        cmd_o.tick_wr = 1'b1;
        if (stat_i.expire) begin
          cmd_o.unlink = 1'b1;
          state_d      = STickRel;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = STickRd;
        end
      end
      STickRel: begin
        cmd_o.free_cur = 1'b1;
        state_d        = STickEmit;
      end
      STickEmit: begin
        if (stat_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KindExpiry;
          state_d         = STickRd;
        end
      end
      SEmit: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          case (op_q)
            OpInsert: cmd_o.emit_kind = KindInsert;
            OpCancel: cmd_o.emit_kind = KindCancel;
            default:  cmd_o.emit_kind = KindTickEnd;
          endcase
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      op_q    <= OpInsert;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

FILE: bench/otrq_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// otrq_checker
// Watches both channels of the timer request queue, keeps its own copy of
// the request pool and compares every result word with the predicted one.
// ----------------------------------------------------------------------------
module otrq_checker
  import otrq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [1:0]        opcode_i,
  input  logic [SemW-1:0]   sem_number_i,
  input  logic [MsgW-1:0]   message_i,
  input  logic [TickW-1:0]  tick_count_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [1:0]        kind_i,
  input  logic [SemW-1:0]   out_sem_i,
  input  logic [MsgW-1:0]   out_message_i,
  input  logic [TickW-1:0]  ticks_left_i,
  input  logic [CountW-1:0] free_entries_i,
  input  logic [CountW-1:0] free_low_mark_i,
  input  logic              pool_error_i,
  input  logic              last_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                results_seen_o,
  output int                expiries_seen_o
);

  typedef struct {
    logic [1:0]        kind;
    logic [SemW-1:0]   sem;
    logic [MsgW-1:0]   msg;
    logic [TickW-1:0]  ticks_left;
    logic [CountW-1:0] free_n;
    logic [CountW-1:0] low_mark;
    logic              err;
    logic              closes;
  } reply_t;

  // shadow of the request pool
  logic [SemW-1:0]   req_sem   [PoolSize];
  logic [MsgW-1:0]   req_msg   [PoolSize];
  logic [TickW-1:0]  req_ticks [PoolSize];
  link_t             req_link  [PoolSize];
  link_t             active_first;
  link_t             free_first;
  logic [CountW-1:0] free_n;
  logic [CountW-1:0] free_floor;

  reply_t awaited[$];
  int     mismatches    = 0;
  int     replies_seen  = 0;
  int     expiries_seen = 0;

  function automatic void reset_pool();
    for (int i = 0; i < PoolSize; i++) begin
      req_link[i] = link_t'(i + 1);
    end
    active_first = NilLink;
    free_first   = '0;
    free_n       = CountW'(PoolSize);
    free_floor   = CountW'(PoolSize);
  endfunction

  function automatic void post(input logic [1:0] kind, input logic [SemW-1:0] sem,
                               input logic [MsgW-1:0] msg, input logic [TickW-1:0] tl,
                               input logic err, input logic closes);
    reply_t r;
    r.kind       = kind;
    r.sem        = sem;
    r.msg        = msg;
    r.ticks_left = tl;
    r.free_n     = free_n;
    r.low_mark   = free_floor;
    r.err        = err;
    r.closes     = closes;
    awaited.push_back(r);
  endfunction

  // freed slots go on the front of the free chain
  function automatic void recycle(input link_t s);
    req_link[s] = free_first;
    free_first  = s;
    free_n      = free_n + 1'b1;
  endfunction

  function automatic void apply_timer_op(input logic [1:0] op, input logic [SemW-1:0] sem,
                                         input logic [MsgW-1:0] msg,
                                         input logic [TickW-1:0] tval);
    link_t            prev;
    link_t            cur;
    link_t            nxt;
    link_t            s;
    int               steps;
    logic [TickW-1:0] left;
    logic             err;
    prev  = NilLink;
    cur   = active_first;
    steps = 0;
    left  = '0;
    case (op)
      OpInsert: begin
        if (free_n == 0 || free_first >= PoolSize) begin
          post(KindInsert, '0, '0, '0, 1'b1, 1'b1);
        end else begin
          s          = free_first;
          free_first = req_link[s];
          free_n     = free_n - 1'b1;
          if (free_n < free_floor) free_floor = free_n;
          err          = (free_n == 0);
          req_sem[s]   = sem;
          req_msg[s]   = msg;
          req_ticks[s] = tval;
          // equal counts: the newcomer goes in front
          while (cur < PoolSize && steps < PoolSize && tval > req_ticks[cur]) begin
            prev = cur;
            cur  = req_link[cur];
            steps++;
          end
          req_link[s] = cur;
          if (prev < PoolSize) req_link[prev] = s;
          else active_first = s;
          post(KindInsert, '0, '0, '0, err, 1'b1);
        end
      end
      OpCancel: begin
        while (cur < PoolSize && steps < PoolSize) begin
          nxt = req_link[cur];
          if (req_sem[cur] == sem && req_msg[cur] == msg) begin
            left = req_ticks[cur];
            if (prev < PoolSize) req_link[prev] = nxt;
            else active_first = nxt;
            recycle(cur);
          end else begin
            prev = cur;
          end
          cur = nxt;
          steps++;
        end
        post(KindCancel, '0, '0, left, 1'b0, 1'b1);
      end
      OpTick: begin
        while (cur < PoolSize && steps < PoolSize) begin
          nxt = req_link[cur];
          // a zero count is not decremented, it simply expires
          if (req_ticks[cur] != 0) req_ticks[cur] = req_ticks[cur] - 1'b1;
          if (req_ticks[cur] == 0) begin
            if (prev < PoolSize) req_link[prev] = nxt;
            else active_first = nxt;
            recycle(cur);
            post(KindExpiry, req_sem[cur], req_msg[cur], '0, 1'b0, 1'b0);
          end else begin
            prev = cur;
          end
          cur = nxt;
          steps++;
        end
        post(KindTickEnd, '0, '0, '0, 1'b0, 1'b1);
      end
      default: ; // unused opcode, no result
    endcase
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    reply_t want;
    if (!rst_ni) begin
      reset_pool();
      awaited.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        replies_seen++;
        if (kind_i == KindExpiry) expiries_seen++;
        if (awaited.size() == 0) begin
          $error("result word with nothing expected, kind %0d", kind_i);
          mismatches++;
        end else begin
          want = awaited.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind_i));
          check_field("out_sem", 32'(want.sem), 32'(out_sem_i));
          check_field("out_message", 32'(want.msg), 32'(out_message_i));
          check_field("ticks_left", 32'(want.ticks_left), 32'(ticks_left_i));
          check_field("free_entries", 32'(want.free_n), 32'(free_entries_i));
          check_field("free_low_mark", 32'(want.low_mark), 32'(free_low_mark_i));
          check_field("pool_error", 32'(want.err), 32'(pool_error_i));
          check_field("last", 32'(want.closes), 32'(last_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_timer_op(opcode_i, sem_number_i, message_i, tick_count_i);
      end
    end
    pending_o       <= awaited.size();
    fail_count_o    <= mismatches;
    results_seen_o  <= replies_seen;
    expiries_seen_o <= expiries_seen;
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the ordered timer request queue: directed corner
// words, then random insert, cancel and tick traffic under bursty input and
// a stalling receiver, checked word by word by otrq_checker.
// ----------------------------------------------------------------------------
module testbench;
  import otrq_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int CycleLimit  = 200000;
  localparam int HoldCycles  = 400;
  localparam int RandomWords = 80;
  localparam int DrainCycles = 120;

  typedef struct {
    logic [SemW-1:0] sem;
    logic [MsgW-1:0] msg;
  } pair_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              in_ready_o;
  logic [1:0]        opcode_i     = OpInsert;
  logic [SemW-1:0]   sem_number_i = '0;
  logic [MsgW-1:0]   message_i    = '0;
  logic [TickW-1:0]  tick_count_i = '0;
  logic              out_valid_o;
  logic              out_ready_i  = 1'b0;
  logic [1:0]        kind_o;
  logic [SemW-1:0]   out_sem_o;
  logic [MsgW-1:0]   out_message_o;
  logic [TickW-1:0]  ticks_left_o;
  logic [CountW-1:0] free_entries_o;
  logic [CountW-1:0] free_low_mark_o;
  logic              pool_error_o;
  logic              last_o;

  logic hold_armed = 1'b0;
  int   burst_left = 0;
  int   cycle_cnt  = 0;
  int   n_insert   = 0;
  int   n_cancel   = 0;
  int   n_tick     = 0;
  int   n_unused   = 0;
  int   mismatch_total;
  int   awaiting;
  int   results_seen;
  int   expiries_seen;

  pair_t placed[$];

  always #5 clk_i = ~clk_i;

  ordered_timer_request_queue_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .sem_number_i    (sem_number_i),
    .message_i       (message_i),
    .tick_count_i    (tick_count_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .out_sem_o       (out_sem_o),
    .out_message_o   (out_message_o),
    .ticks_left_o    (ticks_left_o),
    .free_entries_o  (free_entries_o),
    .free_low_mark_o (free_low_mark_o),
    .pool_error_o    (pool_error_o),
    .last_o          (last_o)
  );

  otrq_checker queue_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .opcode_i        (opcode_i),
    .sem_number_i    (sem_number_i),
    .message_i       (message_i),
    .tick_count_i    (tick_count_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_i          (kind_o),
    .out_sem_i       (out_sem_o),
    .out_message_i   (out_message_o),
    .ticks_left_i    (ticks_left_o),
    .free_entries_i  (free_entries_o),
    .free_low_mark_i (free_low_mark_o),
    .pool_error_i    (pool_error_o),
    .last_i          (last_o),
    .fail_count_o    (mismatch_total),
    .pending_o       (awaiting),
    .results_seen_o  (results_seen),
    .expiries_seen_o (expiries_seen)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timed out after %0d cycles, %0d results outstanding", cycle_cnt, awaiting);
      $display("FAIL ordered_timer_request_queue_top");
      $finish;
    end
  end

  // receiver: changes its stall rate every so often, one long hold-off on request
  initial begin : receiver
    int mode_left;
    int ready_pct;
    bit hold_done;
    mode_left = 0;
    ready_pct = 100;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_armed && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 75;
          2: ready_pct = 35;
          default: ready_pct = 10;
        endcase
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      out_ready_i <= ($urandom_range(1, 100) <= ready_pct);
    end
  end

  // one word: maybe a gap first, then hold valid until the block takes it
  task automatic offer_word(input logic [1:0] op, input logic [SemW-1:0] sem,
                            input logic [MsgW-1:0] msg, input logic [TickW-1:0] tval);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    opcode_i     <= op;
    sem_number_i <= sem;
    message_i    <= msg;
    tick_count_i <= tval;
    in_valid_i   <= 1'b1;
    case (op)
      OpInsert: n_insert++;
      OpCancel: n_cancel++;
      OpTick:   n_tick++;
      default:  n_unused++;
    endcase
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int               done;
    int               pick;
    logic [SemW-1:0]  sem;
    logic [MsgW-1:0]  msg;
    logic [TickW-1:0] tval;
    pair_t            pr;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list
    offer_word(OpTick, 8'h00, 16'h0000, 16'h0000);
    offer_word(OpCancel, 8'h00, 16'h0000, 16'h0000);
    // extremes, zero count, equal counts
    offer_word(OpInsert, 8'hFF, 16'hFFFF, 16'hFFFF);
    offer_word(OpInsert, 8'h00, 16'h0000, 16'h0000);
    offer_word(OpInsert, 8'hA5, 16'h5A5A, 16'd3);
    offer_word(OpInsert, 8'hA5, 16'h5A5A, 16'd3);
    offer_word(OpInsert, 8'h5A, 16'hA5A5, 16'd1);
    offer_word(OpUnused, 8'hFF, 16'hFFFF, 16'hFFFF);
    offer_word(OpTick, 8'h00, 16'h0000, 16'h0000);
    // both duplicates go, ticks left of the later one reported
    offer_word(OpCancel, 8'hA5, 16'h5A5A, 16'h0000);
    // fill the pool, then one insert too many and a busy tick
    repeat (15) offer_word(OpInsert, SemW'($urandom), MsgW'($urandom),
                           TickW'($urandom_range(0, 2)));
    offer_word(OpInsert, 8'h3C, 16'hC3C3, 16'd5);
    offer_word(OpTick, 8'h00, 16'h0000, 16'h0000);
    offer_word(OpCancel, 8'hFF, 16'hFFFF, 16'h0000);

    done = 0;
    while (done < RandomWords) begin
      if (done == RandomWords / 2) hold_armed <= 1'b1;
      // mostly a handful of pairs so that cancels find duplicates
      if ($urandom_range(0, 9) < 7) begin
        sem = SemW'($urandom_range(0, 3));
        msg = MsgW'($urandom_range(0, 3));
      end else begin
        sem = SemW'($urandom);
        msg = MsgW'($urandom);
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        offer_word(OpUnused, sem, msg, TickW'($urandom));
      end else if (pick < 45) begin
        case ($urandom_range(0, 9))
          0:       tval = TickW'($urandom);
          1, 2, 3: tval = TickW'($urandom_range(7, 40));
          default: tval = TickW'($urandom_range(0, 6));
        endcase
        pr.sem = sem;
        pr.msg = msg;
        placed.push_back(pr);
        if (placed.size() > PoolSize) void'(placed.pop_front());
        offer_word(OpInsert, sem, msg, tval);
        done++;
      end else if (pick < 70) begin
        if (placed.size() > 0 && $urandom_range(0, 3) != 0) begin
          pr  = placed[$urandom_range(0, placed.size() - 1)];
          sem = pr.sem;
          msg = pr.msg;
        end
        offer_word(OpCancel, sem, msg, TickW'($urandom));
        done++;
      end else begin
        offer_word(OpTick, sem, msg, TickW'($urandom));
        done++;
      end
    end
    in_valid_i <= 1'b0;

    // pending count from the checker is registered, so it lags behind
    @(posedge clk_i);
    while (awaiting != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Offered %0d inserts, %0d cancels, %0d ticks and %0d unused opcodes.",
             n_insert, n_cancel, n_tick, n_unused);
    $display("Checked %0d result words, %0d of them expiry deliveries.",
             results_seen, expiries_seen);
    if (awaiting != 0) $error("%0d expected results never arrived", awaiting);
    if (mismatch_total == 0 && awaiting == 0) begin
      $display("PASS ordered_timer_request_queue_top");
    end else begin
      $display("FAIL ordered_timer_request_queue_top");
    end
    $finish;
  end

endmodule
